/* rtl/ved_pkg.sv */
// Shared types, constants and codes for the voice endpoint detector.
package ved_pkg;

	// Input command codes.
	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_TICK   = 2'd1;
	localparam logic [1:0] CMD_START  = 2'd2;

	// Session phase codes.
	localparam logic [1:0] PHASE_IDLE     = 2'd0;
	localparam logic [1:0] PHASE_LISTEN   = 2'd1;
	localparam logic [1:0] PHASE_FINISHED = 2'd2;

	// Outcome codes.
	localparam logic [2:0] OUT_NONE      = 3'd0;
	localparam logic [2:0] OUT_SILENCE   = 3'd1;
	localparam logic [2:0] OUT_CAP       = 3'd2;
	localparam logic [2:0] OUT_SHORT     = 3'd3;
	localparam logic [2:0] OUT_NO_SPEECH = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] REG_VOICE_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_NO_SPEECH_MS    = 3'd1;
	localparam logic [2:0] REG_SILENCE_END_MS  = 3'd2;
	localparam logic [2:0] REG_MAX_UTTER_MS    = 3'd3;
	localparam logic [2:0] REG_MIN_UPLOAD      = 3'd4;

	// Field widths.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int THRESH_W   = 15;
	localparam int TIMER_W    = 20;
	localparam int SILENCE_W  = 16;
	localparam int MINB_W     = 16;
	localparam int BYTES_W    = 24;
	localparam int ENERGY_W   = 39;
	localparam int SAMPLE_W   = 16;

	// Shared multiplier operand and product widths.
	localparam int MUL_A_W = 2 * THRESH_W;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Saturation limits.
	localparam logic [TIMER_W-1:0]  TIMER_MAX = {TIMER_W{1'b1}};
	localparam logic [BYTES_W-1:0]  BYTES_MAX = {BYTES_W{1'b1}};
	localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

	// Default frame length limit in samples.
	localparam int FRAME_SAMPLES_MAX_DEF = 256;

	// Register reset values.
	localparam logic [THRESH_W-1:0]  RST_THRESHOLD  = 15'd350;
	localparam logic [TIMER_W-1:0]   RST_NO_SPEECH  = 20'd10000;
	localparam logic [SILENCE_W-1:0] RST_SILENCE    = 16'd550;
	localparam logic [TIMER_W-1:0]   RST_MAX_UTTER  = 20'd60000;
	localparam logic [MINB_W-1:0]    RST_MIN_UPLOAD = 16'd1600;

	// Input transaction payload.
	typedef struct packed {
		logic [1:0]                 command;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       frame_end;
	} in_item_t;

	// Output transaction payload.
	typedef struct packed {
		logic [1:0]         phase;
		logic               voice_seen;
		logic               frame_voiced;
		logic               upload_start;
		logic [2:0]         outcome;
		logic [BYTES_W-1:0] byte_count;
	} out_item_t;

	// Configuration register set.
	typedef struct packed {
		logic [THRESH_W-1:0]  voice_threshold;
		logic [TIMER_W-1:0]   no_speech_timeout_ms;
		logic [SILENCE_W-1:0] silence_end_ms;
		logic [TIMER_W-1:0]   max_utterance_ms;
		logic [MINB_W-1:0]    min_upload_bytes;
	} cfg_t;

endpackage

/* rtl/ved_mul.sv */
// Shared registered multiplier used for sample squares and the threshold product.
module ved_mul (
	input  logic                         clk,
	input  logic [ved_pkg::MUL_A_W-1:0] a,
	input  logic [ved_pkg::MUL_B_W-1:0] b,
	output logic [ved_pkg::MUL_P_W-1:0] p_q
);

	// The product is registered, so it appears in the cycle after the operands.
	always_ff @(posedge clk) begin
		p_q <= ved_pkg::MUL_P_W'(a) * ved_pkg::MUL_P_W'(b);
	end

endmodule

/* rtl/ved_core.sv */
// Sequencer, session state and output register of the voice endpoint detector.
module ved_core #(
	parameter int FRAME_SAMPLES_MAX = ved_pkg::FRAME_SAMPLES_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ved_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  ved_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ved_pkg::out_item_t  out_data
);

	localparam int CW = $clog2(FRAME_SAMPLES_MAX + 1);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ACC  = 3'd1;
	localparam logic [2:0] ST_T2   = 3'd2;
	localparam logic [2:0] ST_CMP  = 3'd3;
	localparam logic [2:0] ST_TICK = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]                    state_q;
	logic                          frame_end_q;
	logic [1:0]                    phase_q;
	logic                          voice_q;
	logic                          upload_q;
	logic [ved_pkg::TIMER_W-1:0]   session_q;
	logic [ved_pkg::TIMER_W-1:0]   quiet_q;
	logic [ved_pkg::BYTES_W-1:0]   bytes_q;
	logic [ved_pkg::ENERGY_W-1:0]  energy_q;
	logic [CW-1:0]                 count_q;
	logic                          voiced_q;
	logic                          pulse_q;
	logic [2:0]                    outcome_q;
	logic                          out_valid_q;
	ved_pkg::out_item_t            out_q;

	logic                          accept;
	logic [ved_pkg::SAMPLE_W-1:0]  raw;
	logic [ved_pkg::SAMPLE_W-1:0]  mag;
	logic [ved_pkg::MUL_A_W-1:0]   mul_a;
	logic [ved_pkg::MUL_B_W-1:0]   mul_b;
	logic [ved_pkg::MUL_P_W-1:0]   prod;
	logic [ved_pkg::ENERGY_W:0]    energy_add;
	logic [CW-1:0]                 count_n;
	logic [ved_pkg::TIMER_W-1:0]   session_n;
	logic [ved_pkg::TIMER_W-1:0]   quiet_n;
	logic                          voice_n;
	logic                          enough;
	logic                          out_load;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Sample magnitude; the most negative sample maps to 32768.
	assign raw = in_data.sample;
	assign mag = raw[ved_pkg::SAMPLE_W-1] ? ved_pkg::SAMPLE_W'(~raw + 1'b1) : raw;

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (state_q)
			ST_IDLE: begin
				mul_a = ved_pkg::MUL_A_W'(mag);
				mul_b = ved_pkg::MUL_B_W'(mag);
			end
			ST_ACC: begin
				mul_a = ved_pkg::MUL_A_W'(cfg.voice_threshold);
				mul_b = ved_pkg::MUL_B_W'(cfg.voice_threshold);
			end
			ST_T2: begin
				mul_a = prod[ved_pkg::MUL_A_W-1:0];
				mul_b = ved_pkg::MUL_B_W'(count_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ved_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	// Datapath helpers for accumulation and timer aging.
	assign energy_add = {1'b0, energy_q} + (ved_pkg::ENERGY_W + 1)'(prod[31:0]);
	assign count_n    = count_q + CW'(1);
	assign session_n  = (session_q == ved_pkg::TIMER_MAX) ? session_q : session_q + 1'b1;
	assign quiet_n    = (quiet_q == ved_pkg::TIMER_MAX) ? quiet_q : quiet_q + 1'b1;
	assign voice_n    = voice_q || (ved_pkg::MUL_P_W'(energy_q) > prod);
	assign enough     = (bytes_q >= ved_pkg::BYTES_W'(cfg.min_upload_bytes));
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// Sequencer and session state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			frame_end_q <= 1'b0;
			phase_q     <= ved_pkg::PHASE_IDLE;
			voice_q     <= 1'b0;
			upload_q    <= 1'b0;
			session_q   <= '0;
			quiet_q     <= '0;
			bytes_q     <= '0;
			energy_q    <= '0;
			count_q     <= '0;
			voiced_q    <= 1'b0;
			pulse_q     <= 1'b0;
			outcome_q   <= ved_pkg::OUT_NONE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						voiced_q    <= 1'b0;
						pulse_q     <= 1'b0;
						outcome_q   <= ved_pkg::OUT_NONE;
						frame_end_q <= in_data.frame_end;
						if (in_data.command == ved_pkg::CMD_START) begin
							phase_q   <= ved_pkg::PHASE_LISTEN;
							voice_q   <= 1'b0;
							upload_q  <= 1'b0;
							session_q <= '0;
							quiet_q   <= '0;
							bytes_q   <= '0;
							energy_q  <= '0;
							count_q   <= '0;
							state_q   <= ST_OUT;
						end else if (phase_q == ved_pkg::PHASE_LISTEN &&
						             in_data.command == ved_pkg::CMD_SAMPLE) begin
							state_q <= ST_ACC;
						end else if (phase_q == ved_pkg::PHASE_LISTEN &&
						             in_data.command == ved_pkg::CMD_TICK) begin
							state_q <= ST_TICK;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_ACC: begin
					// Square is ready: accumulate, count, and check for a frame end.
					energy_q <= energy_add[ved_pkg::ENERGY_W] ? ved_pkg::ENERGY_MAX :
					            energy_add[ved_pkg::ENERGY_W-1:0];
					count_q  <= count_n;
					bytes_q  <= (bytes_q > ved_pkg::BYTES_MAX - 2'd2) ? ved_pkg::BYTES_MAX :
					            bytes_q + 2'd2;
					if (frame_end_q || count_n >= CW'(FRAME_SAMPLES_MAX)) begin
						state_q <= ST_T2;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_T2: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					// Energy against threshold squared times sample count.
					if (ved_pkg::MUL_P_W'(energy_q) > prod) begin
						voiced_q <= 1'b1;
						voice_q  <= 1'b1;
						quiet_q  <= '0;
					end
					energy_q <= '0;
					count_q  <= '0;
					if (voice_n && !upload_q && enough) begin
						upload_q <= 1'b1;
						pulse_q  <= 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_TICK: begin
					// Age timers, then test silence end, no speech, maximum length.
					session_q <= session_n;
					quiet_q   <= quiet_n;
					priority if (voice_q &&
					             quiet_n >= ved_pkg::TIMER_W'(cfg.silence_end_ms)) begin
						phase_q   <= ved_pkg::PHASE_FINISHED;
						outcome_q <= enough ? ved_pkg::OUT_SILENCE : ved_pkg::OUT_SHORT;
					end else if (!voice_q && session_n >= cfg.no_speech_timeout_ms) begin
						phase_q   <= ved_pkg::PHASE_FINISHED;
						outcome_q <= ved_pkg::OUT_NO_SPEECH;
					end else if (voice_q && session_n >= cfg.max_utterance_ms) begin
						phase_q   <= ved_pkg::PHASE_FINISHED;
						outcome_q <= enough ? ved_pkg::OUT_CAP : ved_pkg::OUT_SHORT;
					end else begin
						phase_q <= phase_q;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.phase        <= phase_q;
			out_q.voice_seen   <= voice_q;
			out_q.frame_voiced <= voiced_q;
			out_q.upload_start <= pulse_q;
			out_q.outcome      <= outcome_q;
			out_q.byte_count   <= bytes_q;
		end
	end

endmodule

/* rtl/voice_endpoint_detector.sv */
// Top level of the voice endpoint detector: configuration registers and core.
//
// Input channel (in_valid, in_stall, in_data) carries commands: audio sample,
// one millisecond tick, or session start. A transaction completes when
// in_valid is high and in_stall is low. Each input transaction produces one
// output transaction on (out_valid, out_stall, out_data) with the phase,
// voice flag, frame and upload pulses, outcome code and byte count.
// After accept, a start or an ignored command goes straight to the output state,
// a tick through the tick state, and a sample through the accumulate state and,
// if it ends a frame, the T2 and compare states. The sequencer steps one shared
// multiplier, which squares the sample, then forms threshold squared, then scales
// by the frame sample count. One item is in work at a time and in_stall stays high
// until the sequencer returns to idle as its result is loaded, so no new item is
// taken before the last is through. The output register lets the next item be
// accepted while a result waits; if the receiver stalls, the sequencer holds its
// finished result and keeps in_stall high until the output register frees up.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always
// taken; unknown indexes are ignored. Reset clears the session to idle and
// loads the default register values.
module voice_endpoint_detector #(
	parameter int FRAME_SAMPLES_MAX = ved_pkg::FRAME_SAMPLES_MAX_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  ved_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output ved_pkg::out_item_t                 out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ved_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ved_pkg::CFG_DATA_W-1:0]    cfg_data
);

	ved_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	// Configuration registers, each masked to its own width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.voice_threshold      <= ved_pkg::RST_THRESHOLD;
			cfg_q.no_speech_timeout_ms <= ved_pkg::RST_NO_SPEECH;
			cfg_q.silence_end_ms       <= ved_pkg::RST_SILENCE;
			cfg_q.max_utterance_ms     <= ved_pkg::RST_MAX_UTTER;
			cfg_q.min_upload_bytes     <= ved_pkg::RST_MIN_UPLOAD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ved_pkg::REG_VOICE_THRESHOLD:
					cfg_q.voice_threshold <= cfg_data[ved_pkg::THRESH_W-1:0];
				ved_pkg::REG_NO_SPEECH_MS:
					cfg_q.no_speech_timeout_ms <= cfg_data[ved_pkg::TIMER_W-1:0];
				ved_pkg::REG_SILENCE_END_MS:
					cfg_q.silence_end_ms <= cfg_data[ved_pkg::SILENCE_W-1:0];
				ved_pkg::REG_MAX_UTTER_MS:
					cfg_q.max_utterance_ms <= cfg_data[ved_pkg::TIMER_W-1:0];
				ved_pkg::REG_MIN_UPLOAD:
					cfg_q.min_upload_bytes <= cfg_data[ved_pkg::MINB_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	ved_core #(
		.FRAME_SAMPLES_MAX (FRAME_SAMPLES_MAX)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

/* tb/sv/ved_monitor.sv */
`timescale 1ns / 1ps
// Monitor that predicts every endpoint report and compares it with the detector's output.
module ved_monitor
	import ved_pkg::*;
#(
	parameter int FRAME_LIMIT = FRAME_SAMPLES_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  in_item_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  out_item_t             out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    reports_owed,
	output int                    live_items
);

	// Shadow copy of the configuration registers.
	cfg_t regs;

	// Shadow copy of the session state.
	logic [1:0]          sess_phase;
	logic                heard_voice;
	logic                upload_sent;
	logic [TIMER_W-1:0]  elapsed_ms;
	logic [TIMER_W-1:0]  quiet_ms;
	logic [BYTES_W-1:0]  audio_bytes;
	logic [ENERGY_W-1:0] frame_energy;
	logic [8:0]          frame_len;

	// Reports predicted for accepted commands, oldest first.
	out_item_t pending_reports[$];
	out_item_t forecast;
	out_item_t due;

	// Clear everything that belongs to one listening session.
	task automatic clear_session();
		heard_voice  = 1'b0;
		upload_sent  = 1'b0;
		elapsed_ms   = '0;
		quiet_ms     = '0;
		audio_bytes  = '0;
		frame_energy = '0;
		frame_len    = '0;
	endtask

	// Close the session; an ending with too little audio is reported as too short.
	function automatic logic [2:0] close_session(input logic [2:0] upload_code);
		sess_phase = PHASE_FINISHED;
		return (audio_bytes >= regs.min_upload_bytes) ? upload_code : OUT_SHORT;
	endfunction

	// Advance the session by one command and form the report it produces.
	task automatic endpoint_step(input in_item_t it, output out_item_t rep);
		logic [16:0]       mag;
		logic [33:0]       sq;
		logic [ENERGY_W:0] sum;
		logic [63:0]       bound;
		logic              voiced;
		logic              pulse;
		logic [2:0]        ending;
		voiced = 1'b0;
		pulse  = 1'b0;
		ending = OUT_NONE;
		if (it.command == CMD_START) begin
			clear_session();
			sess_phase = PHASE_LISTEN;
		end else if (it.command == CMD_SAMPLE && sess_phase == PHASE_LISTEN) begin
			// Accumulate the squared magnitude with saturation.
			mag = it.sample[SAMPLE_W-1] ? (17'h10000 - {1'b0, it.sample}) : {1'b0, it.sample};
			sq = mag * mag;
			sum = {1'b0, frame_energy} + sq;
			frame_energy = sum[ENERGY_W] ? ENERGY_MAX : sum[ENERGY_W-1:0];
			frame_len = frame_len + 9'd1;
			audio_bytes = (audio_bytes > BYTES_MAX - 2) ? BYTES_MAX : audio_bytes + 2;
			// A marked sample or a full frame closes the frame.
			if (it.frame_end || frame_len >= FRAME_LIMIT) begin
				bound = 64'(regs.voice_threshold) * 64'(regs.voice_threshold) * 64'(frame_len);
				if (64'(frame_energy) > bound) begin
					voiced      = 1'b1;
					heard_voice = 1'b1;
					quiet_ms    = '0;
				end
				frame_energy = '0;
				frame_len    = '0;
				if (heard_voice && !upload_sent && audio_bytes >= regs.min_upload_bytes) begin
					upload_sent = 1'b1;
					pulse       = 1'b1;
				end
			end
		end else if (it.command == CMD_TICK && sess_phase == PHASE_LISTEN) begin
			// Age the timers, then test silence end, no speech and length cap in turn.
			if (elapsed_ms < TIMER_MAX)
				elapsed_ms = elapsed_ms + 1'b1;
			if (quiet_ms < TIMER_MAX)
				quiet_ms = quiet_ms + 1'b1;
			if (heard_voice && quiet_ms >= regs.silence_end_ms) begin
				ending = close_session(OUT_SILENCE);
			end else if (!heard_voice && elapsed_ms >= regs.no_speech_timeout_ms) begin
				sess_phase = PHASE_FINISHED;
				ending     = OUT_NO_SPEECH;
			end else if (heard_voice && elapsed_ms >= regs.max_utterance_ms) begin
				ending = close_session(OUT_CAP);
			end
		end
		rep.phase        = sess_phase;
		rep.voice_seen   = heard_voice;
		rep.frame_voiced = voiced;
		rep.upload_start = pulse;
		rep.outcome      = ending;
		rep.byte_count   = audio_bytes;
	endtask

	// Compare one report field and log a mismatch.
	task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Watch all three channels on each clock edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.voice_threshold      = RST_THRESHOLD;
			regs.no_speech_timeout_ms = RST_NO_SPEECH;
			regs.silence_end_ms       = RST_SILENCE;
			regs.max_utterance_ms     = RST_MAX_UTTER;
			regs.min_upload_bytes     = RST_MIN_UPLOAD;
			sess_phase = PHASE_IDLE;
			clear_session();
			pending_reports.delete();
			mismatches   = 0;
			reports_owed = 0;
			live_items   = 0;
		end else begin
			// Check each output transaction against the oldest prediction.
			if (out_valid && !out_stall) begin
				if (pending_reports.size() == 0) begin
					$display("%0t: unexpected report, expected none actual %0h", $time, out_data);
					mismatches++;
				end else begin
					due = pending_reports.pop_front();
					check_field("phase", 32'(due.phase), 32'(out_data.phase));
					check_field("voice_seen", 32'(due.voice_seen), 32'(out_data.voice_seen));
					check_field("frame_voiced", 32'(due.frame_voiced), 32'(out_data.frame_voiced));
					check_field("upload_start", 32'(due.upload_start), 32'(out_data.upload_start));
					check_field("outcome", 32'(due.outcome), 32'(out_data.outcome));
					check_field("byte_count", 32'(due.byte_count), 32'(out_data.byte_count));
				end
			end
			// Track register writes.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_VOICE_THRESHOLD: regs.voice_threshold = cfg_data[THRESH_W-1:0];
					REG_NO_SPEECH_MS:    regs.no_speech_timeout_ms = cfg_data[TIMER_W-1:0];
					REG_SILENCE_END_MS:  regs.silence_end_ms = cfg_data[SILENCE_W-1:0];
					REG_MAX_UTTER_MS:    regs.max_utterance_ms = cfg_data[TIMER_W-1:0];
					REG_MIN_UPLOAD:      regs.min_upload_bytes = cfg_data[MINB_W-1:0];
					default: ;
				endcase
			end
			// Predict the report for each accepted input transaction and count it.
			if (in_valid && !in_stall) begin
				live_items++;
				endpoint_step(in_data, forecast);
				pending_reports.push_back(forecast);
			end
			reports_owed = pending_reports.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Top of the voice endpoint detector testbench: clock, reset, stimulus and verdict.
module tb;
	import ved_pkg::*;

	// Codes the package does not name.
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam logic [2:0] REG_UNUSED  = 3'd7;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int PHASE_ITEMS   = 250;
	localparam int RANDOM_PHASES = 8;
	localparam int DRAIN_CYCLES  = 8;
	localparam int HOLD_CYCLES   = 400;

	typedef enum {SMP_LOUD, SMP_QUIET, SMP_MIXED, SMP_ANY} sample_kind_t;
	typedef enum {RX_FLOW, RX_SPOTTY, RX_HELD} rx_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int reports_owed;
	int live_items;
	int cycles;
	int burst_left;
	int cur_thr;
	int hold_asks;
	int holds_done;
	int goal;

	voice_endpoint_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ved_monitor mon (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.reports_owed (reports_owed),
		.live_items   (live_items)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Receiver: free flow, random stalls, solid stalls and requested long hold-offs.
	initial begin
		rx_mode_t mode;
		int left;
		out_stall <= 1'b0;
		holds_done = 0;
		left = 0;
		mode = RX_FLOW;
		forever begin
			@(posedge clk);
			if (hold_asks != holds_done) begin
				holds_done++;
				mode = RX_HELD;
				left = HOLD_CYCLES;
			end else if (left == 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: mode = RX_FLOW;
					4, 5, 6, 7: mode = RX_SPOTTY;
					default:    mode = RX_HELD;
				endcase
				left = (mode == RX_HELD) ? $urandom_range(1, 15) : $urandom_range(1, 40);
			end
			left--;
			case (mode)
				RX_FLOW:   out_stall <= 1'b0;
				RX_SPOTTY: out_stall <= ($urandom_range(0, 99) < 50);
				default:   out_stall <= 1'b1;
			endcase
		end
	end

	function automatic in_item_t mk(input logic [1:0] cmd, input logic [15:0] smp, input logic fe);
		in_item_t it;
		it.command   = cmd;
		it.sample    = smp;
		it.frame_end = fe;
		return it;
	endfunction

	// Offer one input transaction and wait for it; bursts end in random gaps.
	task automatic offer(input in_item_t it);
		int gap;
		in_data  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Write one register; the caller lowers valid after the last write.
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic program_regs(input int thr, input int no_speech, input int silence,
			input int max_len, input int min_bytes);
		set_reg(REG_VOICE_THRESHOLD, thr);
		set_reg(REG_NO_SPEECH_MS, no_speech);
		set_reg(REG_SILENCE_END_MS, silence);
		set_reg(REG_MAX_UTTER_MS, max_len);
		set_reg(REG_MIN_UPLOAD, min_bytes);
		cfg_valid <= 1'b0;
		cur_thr = thr & 16'h7FFF;
	endtask

	// Stop offering and wait until every report has come back and the block is quiet.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (reports_owed != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Pick a sample whose level sits above or below the current threshold, or any random value.
	function automatic logic [15:0] pick_sample(input sample_kind_t kind);
		int mag;
		int lo;
		sample_kind_t k;
		k = kind;
		if (k == SMP_MIXED)
			k = $urandom_range(0, 1) ? SMP_LOUD : SMP_QUIET;
		if (k == SMP_ANY)
			return 16'($urandom);
		if (k == SMP_LOUD) begin
			if ($urandom_range(0, 7) == 0)
				return 16'h8000;
			lo = (cur_thr < 32767) ? cur_thr + 1 : 32767;
			mag = $urandom_range(lo, 32767);
		end else begin
			mag = $urandom_range(0, cur_thr / 2);
		end
		return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
	endfunction

	// One energy frame; an unmarked frame relies on the block's own length limit to close it.
	task automatic play_frame(input int n, input sample_kind_t kind, input logic marked);
		logic fe;
		for (int i = 0; i < n; i++) begin
			fe = (i == n - 1) ? marked : (marked && $urandom_range(0, 19) == 0);
			offer(mk(CMD_SAMPLE, pick_sample(kind), fe));
		end
	endtask

	// One session: mostly frames and ticks, with some noise mixed in.
	task automatic run_session(input int actions);
		int pick;
		if ($urandom_range(0, 9) != 0)
			offer(mk(CMD_START, 16'($urandom), 1'($urandom)));
		repeat (actions) begin
			pick = $urandom_range(0, 199);
			if (pick < 90)
				play_frame($urandom_range(1, 12), sample_kind_t'($urandom_range(0, 3)), 1'b1);
			else if (pick < 170)
				repeat ($urandom_range(1, 4)) offer(mk(CMD_TICK, 16'($urandom), 1'($urandom)));
			else if (pick == 170)
				play_frame($urandom_range(256, 262), sample_kind_t'($urandom_range(0, 3)), 1'b0);
			else if (pick < 185)
				offer(mk(CMD_UNKNOWN, 16'($urandom), 1'($urandom)));
			else
				offer(mk(2'($urandom), 16'($urandom), 1'($urandom)));
		end
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		burst_left = 0;
		hold_asks = 0;
		cur_thr = RST_THRESHOLD;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: commands while idle, extreme samples, threshold edge, restart.
		offer(mk(CMD_SAMPLE, 16'h7FFF, 1'b1));
		offer(mk(CMD_TICK, 16'h0000, 1'b0));
		offer(mk(CMD_UNKNOWN, 16'hFFFF, 1'b1));
		offer(mk(CMD_START, 16'h0000, 1'b0));
		offer(mk(CMD_SAMPLE, 16'h7FFF, 1'b0));
		offer(mk(CMD_SAMPLE, 16'h8000, 1'b1));
		offer(mk(CMD_SAMPLE, 16'h0000, 1'b1));
		offer(mk(CMD_SAMPLE, 16'hFFFF, 1'b0));
		offer(mk(CMD_SAMPLE, 16'h0001, 1'b1));
		offer(mk(CMD_TICK, 16'hFFFF, 1'b1));
		offer(mk(CMD_UNKNOWN, 16'h8000, 1'b1));
		offer(mk(CMD_START, 16'hFFFF, 1'b1));
		offer(mk(CMD_SAMPLE, 16'd350, 1'b1));
		offer(mk(CMD_SAMPLE, 16'd351, 1'b1));
		offer(mk(CMD_TICK, 16'h0000, 1'b0));
		settle();

		// Directed: zero limits and a zero threshold.
		program_regs(0, 0, 0, 0, 0);
		offer(mk(CMD_START, 16'h0000, 1'b0));
		offer(mk(CMD_TICK, 16'h0000, 1'b0));
		offer(mk(CMD_TICK, 16'h0000, 1'b0));
		offer(mk(CMD_SAMPLE, 16'd5, 1'b1));
		offer(mk(CMD_START, 16'h0000, 1'b0));
		offer(mk(CMD_SAMPLE, 16'h0000, 1'b1));
		offer(mk(CMD_SAMPLE, 16'h0001, 1'b1));
		offer(mk(CMD_TICK, 16'h0000, 1'b0));
		settle();

		// Directed: a voiced session that ends with too little audio.
		program_regs(350, 0, 2, 0, 100);
		offer(mk(CMD_START, 16'h0000, 1'b0));
		offer(mk(CMD_SAMPLE, 16'd20000, 1'b1));
		offer(mk(CMD_TICK, 16'h0000, 1'b0));
		settle();

		// Random phases, each under its own register setting.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0) begin
				set_reg(REG_UNUSED, 'hFFFFF);
				program_regs('hFFFFF, 'hFFFFF, 'hFFFFF, 'hFFFFF, 'hFFFFF);
			end else if (p == 3) begin
				program_regs($urandom_range(1, 4000), $urandom_range(0, 2), $urandom_range(0, 2),
					$urandom_range(0, 2), $urandom_range(0, 20));
			end else begin
				program_regs($urandom_range(1, 4000), $urandom_range(5, 80), $urandom_range(1, 30),
					$urandom_range(10, 250), $urandom_range(0, 400));
			end
			if (p == 1 || p == 4)
				hold_asks++;
			goal = live_items + PHASE_ITEMS;
			while (live_items < goal)
				run_session($urandom_range(5, 40));
			settle();
		end

		if (mismatches == 0 && reports_owed == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
